[design/multi_queue_shared_buffer_top_assert.svh]
// Assertion macros for the checks in the top level of this block.
`ifndef MULTI_QUEUE_SHARED_BUFFER_TOP_ASSERT_SVH
`define MULTI_QUEUE_SHARED_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MQSB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MQSB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mqsb_pkg.sv]
`timescale 1ns / 1ps

package mqsb_pkg;

  // Default sizing
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int NUM_QUEUES_DEF = 4;

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int QID_W    = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_ENQ_TERM,
    S_DEQ_DONE,
    S_RESP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                init_wr;
    logic                take;
    logic                enq_commit;
    logic                enq_term;
    logic                deq_fetch;
    logic                deq_commit;
    logic                st_wr;
    logic [STATUS_W-1:0] st_code;
    logic                out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic init_done;
    logic mode_deq;
    logic q_ok;
    logic free_ok;
    logic head_ok;
    logic out_free;
  } sts_t;

endpackage

[design/mqsb_ram.sv]
`timescale 1ns / 1ps

module mqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/mqsb_ctrl.sv]
`timescale 1ns / 1ps

module mqsb_ctrl import mqsb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.st_code = ST_OK;
    in_tready   = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.mode_deq) begin
          if (sts.q_ok && sts.head_ok) begin
            cmd.deq_fetch = 1'b1;
            state_nxt     = S_DEQ_DONE;
          end else begin
            cmd.st_wr   = 1'b1;
            cmd.st_code = ST_EMPTY;
            state_nxt   = S_RESP;
          end
        end else begin
          if (sts.q_ok && sts.free_ok) begin
            cmd.enq_commit = 1'b1;
            state_nxt      = S_ENQ_TERM;
          end else begin
            cmd.st_wr   = 1'b1;
            cmd.st_code = ST_FULL;
            state_nxt   = S_RESP;
          end
        end
      end
      S_ENQ_TERM: begin
        cmd.enq_term = 1'b1;
        cmd.st_wr    = 1'b1;
        cmd.st_code  = ST_OK;
        state_nxt    = S_RESP;
      end
      S_DEQ_DONE: begin
        cmd.deq_commit = 1'b1;
        cmd.st_wr      = 1'b1;
        cmd.st_code    = ST_OK;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

[design/mqsb_dp.sv]
`timescale 1ns / 1ps

module mqsb_dp import mqsb_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic                in_mode,
  input  logic [QID_W-1:0]    in_queue_id,
  input  logic [DATA_W-1:0]   in_data,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_data,
  output logic [STATUS_W-1:0] out_status
);

  localparam int SW   = $clog2(NUM_SLOTS);
  localparam int LW   = $clog2(NUM_SLOTS + 1);
  localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QIW  = (QW > QID_W) ? QW : QID_W;
  localparam int MAXD = (NUM_SLOTS > NUM_QUEUES) ? NUM_SLOTS : NUM_QUEUES;
  localparam int CW   = $clog2(MAXD);

  localparam logic [LW-1:0]  LINK_NULL = LW'(NUM_SLOTS);
  localparam logic [QIW:0]   NQ_LIM    = (QIW + 1)'(NUM_QUEUES);
  localparam logic [CW:0]    NS_LIM    = (CW + 1)'(NUM_SLOTS);
  localparam logic [CW:0]    NQ_INIT   = (CW + 1)'(NUM_QUEUES);
  localparam logic [CW-1:0]  CNT_LAST  = CW'(MAXD - 1);

  // Registers
  logic [CW-1:0]       init_cnt_r, init_cnt_nxt;
  logic                mode_r, mode_nxt;
  logic [QID_W-1:0]    q_r, q_nxt;
  logic [DATA_W-1:0]   din_r, din_nxt;
  logic [SW-1:0]       slot_r, slot_nxt;
  logic [LW-1:0]       free_head_r, free_head_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [DATA_W-1:0]   res_data_r, res_data_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  // Memory ports
  logic              link_we, link_re;
  logic [SW-1:0]     link_wa, link_ra;
  logic [LW-1:0]     link_wd, link_rd;
  logic              data_we, data_re;
  logic [SW-1:0]     data_wa, data_ra;
  logic [DATA_W-1:0] data_rd;
  logic              head_we;
  logic [QW-1:0]     head_wa;
  logic [LW-1:0]     head_wd, head_rd;
  logic              tail_we;
  logic [SW-1:0]     tail_rd;

  logic [QIW-1:0] q_in_w, q_r_w;
  logic [QW-1:0]  q_rd_addr, q_wr_addr;
  logic           init_slot, init_queue;
  logic           head_ok;

  assign q_in_w     = QIW'(in_queue_id);
  assign q_r_w      = QIW'(q_r);
  assign q_rd_addr  = q_in_w[QW-1:0];
  assign q_wr_addr  = q_r_w[QW-1:0];
  assign init_slot  = {1'b0, init_cnt_r} < NS_LIM;
  assign init_queue = {1'b0, init_cnt_r} < NQ_INIT;
  assign head_ok    = head_rd != LINK_NULL;

  // Status towards the controller
  assign sts.init_done = init_cnt_r == CNT_LAST;
  assign sts.mode_deq  = mode_r == MODE_DEQ;
  assign sts.q_ok      = {1'b0, q_r_w} < NQ_LIM;
  assign sts.free_ok   = free_head_r != LINK_NULL;
  assign sts.head_ok   = head_ok;
  assign sts.out_free  = !out_valid_r || out_tready;

  // Link store: init chain, tail append, terminate new tail, free push
  always_comb begin
    link_we = 1'b0;
    link_wa = slot_r;
    link_wd = LINK_NULL;
    if (cmd.init_wr) begin
      link_we = init_slot;
      link_wa = SW'(init_cnt_r);
      link_wd = LW'(init_cnt_r) + LW'(1);
    end else if (cmd.enq_commit) begin
      link_we = head_ok;
      link_wa = tail_rd;
      link_wd = free_head_r;
    end else if (cmd.enq_term) begin
      link_we = 1'b1;
    end else if (cmd.deq_commit) begin
      link_we = 1'b1;
      link_wd = free_head_r;
    end
    link_re = cmd.take || cmd.deq_fetch;
    link_ra = cmd.deq_fetch ? head_rd[SW-1:0] : free_head_r[SW-1:0];
  end

  // Data store
  assign data_we = cmd.enq_commit;
  assign data_wa = free_head_r[SW-1:0];
  assign data_re = cmd.deq_fetch;
  assign data_ra = head_rd[SW-1:0];

  // Queue head and tail stores
  always_comb begin
    head_we = 1'b0;
    head_wa = q_wr_addr;
    head_wd = free_head_r;
    if (cmd.init_wr) begin
      head_we = init_queue;
      head_wa = QW'(init_cnt_r);
      head_wd = LINK_NULL;
    end else if (cmd.enq_commit) begin
      head_we = !head_ok;
    end else if (cmd.deq_commit) begin
      head_we = 1'b1;
      head_wd = link_rd;
    end
  end

  assign tail_we = cmd.enq_commit;

  mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_SLOTS), .AW(SW)) u_link (
    .clk(clk), .wr_en(link_we), .wr_addr(link_wa), .wr_data(link_wd),
    .rd_en(link_re), .rd_addr(link_ra), .rd_data(link_rd)
  );

  mqsb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_SLOTS), .AW(SW)) u_data (
    .clk(clk), .wr_en(data_we), .wr_addr(data_wa), .wr_data(din_r),
    .rd_en(data_re), .rd_addr(data_ra), .rd_data(data_rd)
  );

  mqsb_ram #(.WIDTH(LW), .DEPTH(NUM_QUEUES), .AW(QW)) u_head (
    .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
    .rd_en(cmd.take), .rd_addr(q_rd_addr), .rd_data(head_rd)
  );

  mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES), .AW(QW)) u_tail (
    .clk(clk), .wr_en(tail_we), .wr_addr(q_wr_addr), .wr_data(free_head_r[SW-1:0]),
    .rd_en(cmd.take), .rd_addr(q_rd_addr), .rd_data(tail_rd)
  );

  // Next values of the working registers
  always_comb begin
    init_cnt_nxt  = init_cnt_r;
    mode_nxt      = mode_r;
    q_nxt         = q_r;
    din_nxt       = din_r;
    slot_nxt      = slot_r;
    free_head_nxt = free_head_r;
    res_st_nxt    = res_st_r;
    res_data_nxt  = res_data_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;

    if (cmd.init_wr && !sts.init_done) begin
      init_cnt_nxt = init_cnt_r + CW'(1);
    end
    if (cmd.take) begin
      mode_nxt = in_mode;
      q_nxt    = in_queue_id;
      din_nxt  = in_data;
    end
    // Slot in flight: free-list head for enqueue, queue head for dequeue
    if (cmd.enq_commit) begin
      slot_nxt      = free_head_r[SW-1:0];
      free_head_nxt = link_rd;
    end
    if (cmd.deq_fetch) begin
      slot_nxt = head_rd[SW-1:0];
    end
    if (cmd.deq_commit) begin
      free_head_nxt = LW'(slot_r);
    end
    if (cmd.st_wr) begin
      res_st_nxt   = cmd.st_code;
      res_data_nxt = cmd.deq_commit ? data_rd : '0;
    end
    // Output word register
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      out_st_nxt    = res_st_r;
      out_data_nxt  = res_data_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r  <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    q_r        <= q_nxt;
    din_r      <= din_nxt;
    slot_r     <= slot_nxt;
    res_st_r   <= res_st_nxt;
    res_data_r <= res_data_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_st_r;

endmodule

[design/multi_queue_shared_buffer_top.sv]
// Several FIFO queues sharing one slot store, each queue a linked list, with
// unused slots kept on a free list.
// Input channel (in_*): one word per operation. in_tuser carries the opcode
// (enqueue or dequeue) and the queue number; in_tdata carries the value.
// Result channel (out_*): exactly one word per operation, in order. out_tdata
// is the dequeued value (zero otherwise), out_tuser the status: ok, store
// full on enqueue, or queue empty on dequeue.
// Timing: an accepted word goes from S_LOOK through S_ENQ_TERM or S_DEQ_DONE
// to S_RESP on success, straight to S_RESP on failure; S_RESP loads the
// result into the output register. The limit is the link store, with one
// write port and a registered read, which each successful operation reads
// and then writes (twice for an enqueue onto a non-empty queue).
// One operation is in flight at a time; in_tready is high only when the
// sequencer is idle. A finished result sits in the output register, so the
// next word is taken while it waits for out_tready; when the receiver stalls
// longer, the following result waits in the sequencer and in_tready drops.
// Reset: rst_n (synchronous, active low) starts a sweep of the init counter
// up to max(NUM_SLOTS, NUM_QUEUES) - 1 that chains every slot onto the free
// list and empties every queue; in_tready stays low until it ends.
`timescale 1ns / 1ps
`include "multi_queue_shared_buffer_top_assert.svh"

module multi_queue_shared_buffer_top import mqsb_pkg::*; #(
  parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
  parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [DATA_W-1:0]        in_tdata,   // [31:0] data_in
  input  logic [QID_W:0]           in_tuser,   // [0] mode, [2:1] queue_id
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [DATA_W-1:0]        out_tdata,  // [31:0] data_out
  output logic [STATUS_W-1:0]      out_tuser   // [1:0] status
);

  cmd_t cmd;
  sts_t sts;

  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mqsb_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_QUEUES (NUM_QUEUES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_tuser[0]),
    .in_queue_id (in_tuser[QID_W:1]),
    .in_data     (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_data    (out_tdata),
    .out_status  (out_tuser)
  );

  // Checks
  `MQSB_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free, "result loaded over a held word")
  `MQSB_ASSERT_IMP(a_enq_ok, cmd.enq_commit, sts.q_ok && sts.free_ok && !sts.mode_deq,
                   "enqueue committed without a free slot")
  `MQSB_ASSERT_IMP(a_deq_ok, cmd.deq_fetch, sts.q_ok && sts.head_ok && sts.mode_deq,
                   "dequeue fetched from an empty queue")
  `MQSB_ASSERT_NXT(a_one_flight, in_tvalid && in_tready, !in_tready && !cmd.out_load,
                   "second word taken while one is in flight")

endmodule
